// ===== sv/rgbhsl_pkg.sv =====
// Shared constants and types for the RGB to HSL converter.
package rgbhsl_pkg;

    localparam int unsigned RES_BITS = 16;
    localparam int unsigned QUOT_BITS = 16;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

endpackage

// ===== sv/rgbhsl_div_stage.sv =====
// One restoring-division step: one quotient bit per pipeline stage.
module rgbhsl_div_stage
    import rgbhsl_pkg::*;
#(
    parameter int unsigned DEN_BITS = 11,
    parameter int unsigned REM_BITS = 12
)
(
    input  logic [REM_BITS-1:0] rem_in,
    input  logic [DEN_BITS-1:0] den,
    input  logic                num_bit,
    output logic [REM_BITS-1:0] rem_out,
    output logic                q_bit
);

    logic [REM_BITS:0] trial;
    logic [REM_BITS:0] den_ext;

    assign trial = {rem_in, num_bit};
    assign den_ext = {{(REM_BITS + 1 - DEN_BITS){1'b0}}, den};
    assign q_bit = (trial >= den_ext);
    assign rem_out = q_bit ? REM_BITS'(trial - den_ext) : REM_BITS'(trial);

endmodule

// ===== sv/rgbhsl_divider.sv =====
// Pipelined radix-2 divider: quotient bit per stage, remainders registered.
module rgbhsl_divider
    import rgbhsl_pkg::*;
#(
    parameter int unsigned NUM_BITS = 32,
    parameter int unsigned DEN_BITS = 11,
    parameter int unsigned Q_BITS   = 16,
    parameter int unsigned TAG_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    input  logic [TAG_BITS-1:0] tag_in,
    output logic                out_valid,
    output logic [Q_BITS-1:0]   quot,
    output logic [TAG_BITS-1:0] tag_out
);

    // The quotient is known to fit Q_BITS, so the top numerator bits
    // start as the remainder and stay below the divisor.
    localparam int unsigned REM_BITS = DEN_BITS + 1;
    localparam int unsigned HEAD_BITS = NUM_BITS - Q_BITS;

    // Entry s holds what stage s hands on to stage s+1.
    logic [REM_BITS-1:0] rem_reg [Q_BITS];
    logic [Q_BITS-1:0]   low_reg [Q_BITS];
    logic [Q_BITS-1:0]   q_reg   [Q_BITS];
    logic [DEN_BITS-1:0] den_reg [Q_BITS];
    logic [TAG_BITS-1:0] tag_reg [Q_BITS];
    logic                vld_reg [Q_BITS];

    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_stage
        logic [REM_BITS-1:0] rem_cur;
        logic [Q_BITS-1:0]   low_cur;
        logic [Q_BITS-1:0]   q_cur;
        logic [DEN_BITS-1:0] den_cur;
        logic [TAG_BITS-1:0] tag_cur;
        logic                vld_cur;
        logic [REM_BITS-1:0] rem_next;
        logic                qb_next;

        if (s == 0)
        begin : g_head
            assign rem_cur = REM_BITS'(num[NUM_BITS-1 -: HEAD_BITS]);
            assign low_cur = num[Q_BITS-1:0];
            assign q_cur   = '0;
            assign den_cur = den;
            assign tag_cur = tag_in;
            assign vld_cur = in_valid;
        end
        else
        begin : g_body
            assign rem_cur = rem_reg[s-1];
            assign low_cur = low_reg[s-1];
            assign q_cur   = q_reg[s-1];
            assign den_cur = den_reg[s-1];
            assign tag_cur = tag_reg[s-1];
            assign vld_cur = vld_reg[s-1];
        end

        rgbhsl_div_stage #(.DEN_BITS(DEN_BITS), .REM_BITS(REM_BITS)) u_step (
            .rem_in (rem_cur),
            .den    (den_cur),
            .num_bit(low_cur[Q_BITS-1]),
            .rem_out(rem_next),
            .q_bit  (qb_next)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            low_reg[s] <= {low_cur[Q_BITS-2:0], 1'b0};
            q_reg[s]   <= {q_cur[Q_BITS-2:0], qb_next};
            den_reg[s] <= den_cur;
            tag_reg[s] <= tag_cur;
        end
    end

    assign out_valid = vld_reg[Q_BITS-1];
    assign quot      = q_reg[Q_BITS-1];
    assign tag_out   = tag_reg[Q_BITS-1];

endmodule

// ===== sv/rgbhsl_front.sv =====
// Front stages: max, min, chroma, lightness and the divider operands.
module rgbhsl_front
    import rgbhsl_pkg::*;
#(
    parameter int unsigned CHANNEL_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [CHANNEL_BITS-1:0]   red,
    input  logic [CHANNEL_BITS-1:0]   green,
    input  logic [CHANNEL_BITS-1:0]   blue,
    input  logic [CHANNEL_BITS-1:0]   alpha_in,
    output logic                      out_valid,
    output logic                      grey,
    output logic [CHANNEL_BITS+17:0]  sat_num,
    output logic [CHANNEL_BITS-1:0]   sat_den,
    output logic [CHANNEL_BITS+18:0]  hue_num,
    output logic [CHANNEL_BITS+2:0]   hue_den,
    output logic [RES_BITS-1:0]       light,
    output logic [CHANNEL_BITS-1:0]   alpha
);

    localparam int unsigned CB = CHANNEL_BITS;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    // Lightness divides by the constant 2*FULL through a rounded-up
    // reciprocal; its error stays below one step of the exact quotient.
    localparam logic [63:0] FULL_W = (64'd1 << CB) - 64'd1;
    localparam int unsigned LSH = 2 * CB + 2;
    localparam logic [CB+17:0] LMUL =
        (CB+18)'(((64'd65535 << LSH) + 2 * FULL_W - 64'd1) / (2 * FULL_W));

    // Stage 1: max, min and sector.
    logic          v1_reg;
    logic [CB-1:0] hi1_reg, lo1_reg, r1_reg, g1_reg, b1_reg, a1_reg;
    sector_t       sect1_reg;

    logic [CB-1:0] hi_next, lo_next;
    sector_t       sect_next;

    always_comb
    begin
        hi_next = red;
        lo_next = red;
        sect_next = SECT_RED;
        if (green > hi_next) hi_next = green;
        if (blue > hi_next) hi_next = blue;
        if (green < lo_next) lo_next = green;
        if (blue < lo_next) lo_next = blue;
        if (hi_next == red) sect_next = SECT_RED;
        else if (hi_next == green) sect_next = SECT_GREEN;
        else sect_next = SECT_BLUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hi1_reg <= hi_next;
        lo1_reg <= lo_next;
        r1_reg <= red;
        g1_reg <= green;
        b1_reg <= blue;
        a1_reg <= alpha_in;
        sect1_reg <= sect_next;
    end

    // Stage 2: chroma, sum, saturation divisor and hue numerator.
    logic            v2_reg;
    logic [CB-1:0]   chroma2_reg;
    logic [CB:0]     sum2_reg;
    logic [CB-1:0]   sden2_reg;
    logic [CB+2:0]   hval2_reg;
    logic [CB-1:0]   a2_reg;

    logic [CB-1:0]   chroma_next;
    logic [CB:0]     sum_next;
    logic [CB:0]     dist_next;
    logic [CB-1:0]   sden_next;
    logic [CB+2:0]   hval_next;
    logic [CB+2:0]   c_ext;

    always_comb
    begin
        chroma_next = hi1_reg - lo1_reg;
        sum_next = {1'b0, hi1_reg} + {1'b0, lo1_reg};
        dist_next = (sum_next >= {1'b0, FULL}) ? (sum_next - {1'b0, FULL})
                                               : ({1'b0, FULL} - sum_next);
        sden_next = FULL - CB'(dist_next);
        c_ext = (CB+3)'(chroma_next);
        unique case (sect1_reg)
            SECT_RED:
            begin
                if (g1_reg >= b1_reg)
                    hval_next = (CB+3)'(g1_reg - b1_reg);
                else
                    hval_next = (c_ext << 2) + (c_ext << 1)
                                - (CB+3)'(b1_reg - g1_reg);
            end
            SECT_GREEN:
                hval_next = (c_ext << 1) + (CB+3)'(b1_reg) - (CB+3)'(r1_reg);
            default:
                hval_next = (c_ext << 2) + (CB+3)'(r1_reg) - (CB+3)'(g1_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        chroma2_reg <= chroma_next;
        sum2_reg <= sum_next;
        sden2_reg <= sden_next;
        hval2_reg <= hval_next;
        a2_reg <= a1_reg;
    end

    // Stage 3: scaled numerators; the saturation one, times 65535, is a shift and a subtract.
    logic v3_reg;
    logic [CB+17:0] snum3_reg;
    logic [CB-1:0]  sden3_reg;
    logic [CB+18:0] hnum3_reg;
    logic [CB+2:0]  hden3_reg;
    logic [RES_BITS-1:0] light3_reg;
    logic           grey3_reg;
    logic [CB-1:0]  a3_reg;

    logic [CB+2:0] cx;
    logic [2*CB+18:0] lprod;
    assign cx = (CB+3)'(chroma2_reg);
    assign lprod = (2*CB+19)'(sum2_reg) * (2*CB+19)'(LMUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        snum3_reg <= ((CB+18)'(chroma2_reg) << 16) - (CB+18)'(chroma2_reg);
        sden3_reg <= (chroma2_reg == '0) ? CB'(1) : sden2_reg;
        hnum3_reg <= (CB+19)'(hval2_reg) << 16;
        hden3_reg <= (chroma2_reg == '0) ? (CB+3)'(1) : ((cx << 2) + (cx << 1));
        light3_reg <= lprod[LSH +: RES_BITS];
        grey3_reg <= (chroma2_reg == '0);
        a3_reg <= a2_reg;
    end

    assign out_valid = v3_reg;
    assign grey = grey3_reg;
    assign sat_num = snum3_reg;
    assign sat_den = sden3_reg;
    assign hue_num = hnum3_reg;
    assign hue_den = hden3_reg;
    assign light = light3_reg;
    assign alpha = a3_reg;

endmodule

// ===== sv/rgb_to_hsl_convert.sv =====
// Top level of the pipelined RGB to HSL converter.
//
//   channel  | ports                                        | handshake
//   pixel in | red, green, blue, alpha_in                   | start (busy tied low)
//   result   | hue, saturation, lightness, alpha_out        | done strobe, one cycle
//
// One pixel enters per cycle; each result passes through three front stages,
// sixteen restoring divider stages (one quotient bit each) and the output
// register. Lightness is finished in the front stages and rides along with
// the saturation divider. busy is always low.
// Reset clears the valid bits only. The receiver cannot stall, so no
// back-pressure path exists; every accepted word leaves exactly once.
module rgb_to_hsl_convert
    import rgbhsl_pkg::*;
#(
    parameter int unsigned CHANNEL_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    input  logic [CHANNEL_BITS-1:0] alpha_in,
    output logic                    done,
    output logic [RES_BITS-1:0]     hue,
    output logic [RES_BITS-1:0]     saturation,
    output logic [RES_BITS-1:0]     lightness,
    output logic [CHANNEL_BITS-1:0] alpha_out
);

    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned TAG = CB + 1;

    logic                f_valid, f_grey;
    logic [CB+17:0]      sat_num;
    logic [CB-1:0]       sat_den, f_alpha;
    logic [CB+18:0]      hue_num;
    logic [CB+2:0]       hue_den;
    logic [RES_BITS-1:0] f_light;

    assign busy = 1'b0;

    rgbhsl_front #(.CHANNEL_BITS(CB)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha_in (alpha_in),
        .out_valid(f_valid),
        .grey     (f_grey),
        .sat_num  (sat_num),
        .sat_den  (sat_den),
        .hue_num  (hue_num),
        .hue_den  (hue_den),
        .light    (f_light),
        .alpha    (f_alpha)
    );

    logic                 hue_v, sat_v;
    logic [QUOT_BITS-1:0] hue_q, sat_q;
    logic [TAG-1:0]       tag_q;
    logic [RES_BITS-1:0]  light_q;

    rgbhsl_divider #(.NUM_BITS(CB+19), .DEN_BITS(CB+3), .Q_BITS(QUOT_BITS),
                     .TAG_BITS(TAG)) u_hue_div (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid),
        .num(hue_num), .den(hue_den), .tag_in({f_grey, f_alpha}),
        .out_valid(hue_v), .quot(hue_q), .tag_out(tag_q)
    );

    rgbhsl_divider #(.NUM_BITS(CB+18), .DEN_BITS(CB), .Q_BITS(QUOT_BITS),
                     .TAG_BITS(RES_BITS)) u_sat_div (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid),
        .num(sat_num), .den(sat_den), .tag_in(f_light),
        .out_valid(sat_v), .quot(sat_q), .tag_out(light_q)
    );

    logic                done_reg;
    logic [RES_BITS-1:0] hue_reg, sat_reg, light_reg;
    logic [CB-1:0]       alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= hue_v & sat_v;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= tag_q[TAG-1] ? '0 : hue_q;
        sat_reg   <= tag_q[TAG-1] ? '0 : sat_q;
        light_reg <= light_q;
        alpha_reg <= tag_q[CB-1:0];
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;
    assign alpha_out  = alpha_reg;

endmodule

// ===== bench/hsl_checker.sv =====
// Checker that predicts HSL results for accepted pixels and compares them with the block's output.
module hsl_checker
    import rgbhsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic [7:0]          alpha_in,
    input  logic                done,
    input  logic [RES_BITS-1:0] hue,
    input  logic [RES_BITS-1:0] saturation,
    input  logic [RES_BITS-1:0] lightness,
    input  logic [7:0]          alpha_out,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] h;
        logic [15:0] s;
        logic [15:0] l;
        logic [7:0]  a;
    } hsl_word_t;

    hsl_word_t hsl_expected[$];

    function automatic hsl_word_t hsl_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] a);
        int unsigned hi;
        int unsigned lo;
        int unsigned chroma;
        int unsigned sum;
        int unsigned offset;
        int unsigned value;
        hsl_word_t w;
        hi = 32'(r);
        lo = 32'(r);
        if (g > hi) hi = 32'(g);
        if (b > hi) hi = 32'(b);
        if (g < lo) lo = 32'(g);
        if (b < lo) lo = 32'(b);
        chroma = hi - lo;
        sum = hi + lo;
        w.l = 16'((sum * 65535) / 510);
        w.s = 0;
        w.h = 0;
        w.a = a;
        if (chroma != 0)
        begin
            offset = (sum >= 255) ? sum - 255 : 255 - sum;
            w.s = 16'((chroma * 65535) / (255 - offset));
            // Red wins ties for the maximum, then green.
            if (hi == 32'(r))
                value = (g >= b) ? 32'(g) - 32'(b) : 6 * chroma - (32'(b) - 32'(g));
            else if (hi == 32'(g))
                value = 2 * chroma + 32'(b) - 32'(r);
            else
                value = 4 * chroma + 32'(r) - 32'(g);
            w.h = 16'((value * 65536) / (6 * chroma));
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsl_word_t want;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            hsl_expected.delete();
        end
        else
        begin
            if (done)
            begin
                if (hsl_expected.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result word h=%0d s=%0d l=%0d a=%0d",
                                 hue, saturation, lightness, alpha_out);
                    errors <= errors + 1;
                end
                else
                begin
                    want = hsl_expected.pop_front();
                    if (want != {hue, saturation, lightness, alpha_out})
                    begin
                        if (errors < 10)
                            $display({"mismatch: expected h=%0d s=%0d l=%0d a=%0d, ",
                                      "got h=%0d s=%0d l=%0d a=%0d"},
                                     want.h, want.s, want.l, want.a,
                                     hue, saturation, lightness, alpha_out);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                hsl_expected.push_back(hsl_of_pixel(red, green, blue, alpha_in));
            pending <= hsl_expected.size();
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the RGB to HSL bench: clock, reset, pixel stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsl_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [7:0] red = 0, green = 0, blue = 0, alpha_in = 0;
    logic done;
    logic [RES_BITS-1:0] hue, saturation, lightness;
    logic [7:0] alpha_out;
    int errors;
    int pending;
    int unsigned cycles = 0;

    always #5 clk = ~clk;

    rgb_to_hsl_convert DUT (.*);
    hsl_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("[rgb_to_hsl_convert] ERROR");
            $finish;
        end
    end

    // Presents one word and holds it until accepted; start stays high into the next word.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        start <= 1;
        red <= r;
        green <= g;
        blue <= b;
        alpha_in <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_idle();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0)
        begin
            start <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [7:0] v[6];
        logic [7:0] r, g, b;
        v = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Extremes, greys, each hue sector and each tie for the maximum.
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 255);
        send_pixel(128, 128, 128, 85);
        send_pixel(255, 0, 0, 170);
        send_pixel(0, 255, 0, 1);
        send_pixel(0, 0, 255, 254);
        send_pixel(255, 0, 1, 3);
        send_pixel(255, 1, 0, 7);
        send_pixel(200, 200, 10, 9);
        send_pixel(200, 10, 200, 11);
        send_pixel(10, 200, 200, 13);
        send_pixel(255, 254, 254, 15);
        send_pixel(1, 0, 0, 17);
        send_pixel(127, 128, 0, 19);
        send_pixel(255, 128, 0, 21);
        send_pixel(0, 128, 255, 23);
        start <= 0;
        wait (pending == 0);
        @(posedge clk);
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 700)
            begin
                start <= 0;
                wait (pending == 0);
                @(posedge clk);
            end
            case ($urandom_range(0, 3))
                0:
                begin
                    r = v[$urandom_range(0, 5)];
                    g = v[$urandom_range(0, 5)];
                    b = v[$urandom_range(0, 5)];
                end
                1:
                begin
                    r = 8'($urandom);
                    g = r;
                    b = ($urandom_range(0, 1)) ? r : 8'($urandom);
                end
                default:
                begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
            endcase
            send_pixel(r, g, b, 8'($urandom));
            maybe_idle();
        end
        start <= 0;
        wait (pending == 0);
        repeat (25) @(posedge clk);
        if (errors == 0)
            $display("[rgb_to_hsl_convert] OK");
        else
            $display("[rgb_to_hsl_convert] ERROR");
        $finish;
    end
endmodule
